// ----- design/cft_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cft_pkg
// Shared types and constants of the correlation feedback tracker.
// ----------------------------------------------------------------------------
package cft_pkg;

    localparam int CFT_TABLE_DEPTH = 8;

    // command codes of an incoming transaction
    typedef enum logic [2:0] {
        OP_TRACK   = 3'd0,
        OP_RESULT  = 3'd1,
        OP_SERVICE = 3'd2,
        OP_POP     = 3'd3,
        OP_DISC    = 3'd4
    } op_t;

    // feedback kinds stored in the ring
    localparam logic [1:0] KIND_SEM_ACC = 2'd0;
    localparam logic [1:0] KIND_SEM_REJ = 2'd1;
    localparam logic [1:0] KIND_SVC_ACC = 2'd2;
    localparam logic [1:0] KIND_SVC_REJ = 2'd3;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] corr_id;
        logic        accepted;
    } item_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] feedback_id;
        logic [1:0]  feedback_kind;
        logic [3:0]  pend_count;
        logic [3:0]  queued_count;
    } result_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] id;
    } ring_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_LAST_RD,
        ST_MOVE,
        ST_POP_RD,
        ST_POP,
        ST_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic scan_step;
        logic tab_append;
        logic last_rd;
        logic tab_move;
        logic ring_push;
        logic ring_rd;
        logic ring_pop;
        logic clear;
        logic set_ok;
        logic emit;
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_t  op;
        logic id_zero;
        logic tab_full;
        logic ring_full;
        logic ring_empty;
        logic hit;
        logic scan_end;
        logic out_free;
    } ctl_sts_t;

endpackage

// ----- design/cft_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cft_ctrl
// Sequencer: steps one transaction through lookup, table and ring updates.
// ----------------------------------------------------------------------------
module cft_ctrl
    import cft_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  ctl_sts_t sts,
    output ctl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (sts.op)
                    OP_TRACK:
                    begin
                        if (sts.id_zero || sts.tab_full)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    OP_RESULT:
                    begin
                        state_next = ST_SCAN;
                    end
                    OP_SERVICE:
                    begin
                        if (!sts.id_zero && !sts.ring_full)
                        begin
                            cmd.ring_push = 1'b1;
                            cmd.set_ok    = 1'b1;
                        end
                        state_next = ST_DONE;
                    end
                    OP_POP:
                    begin
                        if (sts.ring_empty)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_POP_RD;
                        end
                    end
                    OP_DISC:
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_DONE;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SCAN:
            begin
                if (sts.hit)
                begin
                    if (sts.op == OP_TRACK)
                    begin
                        cmd.set_ok = 1'b1;
                        state_next = ST_DONE;
                    end
                    else if (sts.ring_full)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        cmd.ring_push = 1'b1;
                        cmd.set_ok    = 1'b1;
                        state_next    = ST_LAST_RD;
                    end
                end
                else if (sts.scan_end)
                begin
                    if (sts.op == OP_TRACK)
                    begin
                        cmd.tab_append = 1'b1;
                        cmd.set_ok     = 1'b1;
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    // hold the address of a hit: step only while no match
                    cmd.scan_step = 1'b1;
                end
            end
            ST_LAST_RD:
            begin
                cmd.last_rd = 1'b1;
                state_next  = ST_MOVE;
            end
            ST_MOVE:
            begin
                cmd.tab_move = 1'b1;
                state_next   = ST_DONE;
            end
            ST_POP_RD:
            begin
                cmd.ring_rd = 1'b1;
                state_next  = ST_POP;
            end
            ST_POP:
            begin
                cmd.ring_pop = 1'b1;
                cmd.set_ok   = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/cft_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cft_datapath
// Pending id table, feedback ring, counters and the result register.
// ----------------------------------------------------------------------------
module cft_datapath
    import cft_pkg::*;
#(
    parameter int TABLE_DEPTH = CFT_TABLE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  item_t    req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output result_t  rsp,
    input  ctl_cmd_t cmd,
    output ctl_sts_t sts
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // captured transaction
    op_t         op_reg;
    logic [31:0] id_reg;
    logic        acc_reg;

    logic        ok_reg;
    logic [31:0] fid_reg;
    logic [1:0]  kind_reg;

    logic [CW-1:0] pend_total_reg;
    logic [CW-1:0] ring_total_reg;
    logic [AW-1:0] ring_head_reg;

    // pending table memory and its scan
    logic [31:0]   pend_mem [TABLE_DEPTH];
    logic [31:0]   pend_rdata_reg;
    logic [CW-1:0] scan_idx_reg;
    logic [AW-1:0] pos_reg;
    logic          rd_vld_reg;
    logic          scan_issue;
    logic          pend_rd_en;
    logic [AW-1:0] pend_rd_addr;
    logic [CW-1:0] last_cnt;
    logic          pend_we;
    logic [AW-1:0] pend_waddr;
    logic [31:0]   pend_wdata;

    // feedback ring memory
    ring_entry_t   ring_mem [TABLE_DEPTH];
    ring_entry_t   ring_rdata_reg;
    ring_entry_t   push_entry;
    logic [CW:0]   slot_sum;
    logic [CW:0]   slot_wrap;
    logic [AW-1:0] push_slot;
    logic [AW-1:0] head_inc;

    result_t       rsp_reg;
    logic          rsp_valid_reg;
    logic [CW+3:0] pend_ext;
    logic [CW+3:0] ring_ext;

    assign scan_issue   = cmd.scan_step && (scan_idx_reg < pend_total_reg);
    assign last_cnt     = pend_total_reg - CW'(1);
    assign pend_rd_en   = scan_issue || cmd.last_rd;
    assign pend_rd_addr = cmd.last_rd ? last_cnt[AW-1:0] : scan_idx_reg[AW-1:0];
    assign pend_we      = cmd.tab_append || cmd.tab_move;
    assign pend_waddr   = cmd.tab_move ? pos_reg : pend_total_reg[AW-1:0];
    assign pend_wdata   = cmd.tab_move ? pend_rdata_reg : id_reg;

    // removal copies the last entry into the hole; ids are unique so order is free
    always_ff @(posedge clk)
    begin
        if (pend_rd_en)
        begin
            pend_rdata_reg <= pend_mem[pend_rd_addr];
        end
        if (pend_we)
        begin
            pend_mem[pend_waddr] <= pend_wdata;
        end
    end

    // tail slot = (head + total) mod depth, sum stays below twice the depth
    assign slot_sum  = {{(CW + 1 - AW){1'b0}}, ring_head_reg} + {1'b0, ring_total_reg};
    assign slot_wrap = (slot_sum >= (CW + 1)'(TABLE_DEPTH)) ?
                       slot_sum - (CW + 1)'(TABLE_DEPTH) : slot_sum;
    assign push_slot = slot_wrap[AW-1:0];
    assign head_inc  = (ring_head_reg == AW'(TABLE_DEPTH - 1)) ? '0 :
                       ring_head_reg + AW'(1);

    always_comb
    begin
        push_entry.id = id_reg;
        if (op_reg == OP_SERVICE)
        begin
            push_entry.kind = acc_reg ? KIND_SVC_ACC : KIND_SVC_REJ;
        end
        else
        begin
            push_entry.kind = acc_reg ? KIND_SEM_ACC : KIND_SEM_REJ;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ring_rd)
        begin
            ring_rdata_reg <= ring_mem[ring_head_reg];
        end
        if (cmd.ring_push)
        begin
            ring_mem[push_slot] <= push_entry;
        end
    end

    // transaction capture and per-item result fields
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op_t'(req.cmd);
            id_reg  <= req.corr_id;
            acc_reg <= req.accepted;
        end
        if (cmd.load)
        begin
            fid_reg  <= '0;
            kind_reg <= '0;
        end
        else if (cmd.ring_pop)
        begin
            fid_reg  <= ring_rdata_reg.id;
            kind_reg <= ring_rdata_reg.kind;
        end
        if (scan_issue)
        begin
            pos_reg <= scan_idx_reg[AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg         <= 1'b0;
            scan_idx_reg   <= '0;
            rd_vld_reg     <= 1'b0;
            pend_total_reg <= '0;
            ring_total_reg <= '0;
            ring_head_reg  <= '0;
        end
        else
        begin
            rd_vld_reg <= scan_issue;
            if (cmd.load)
            begin
                ok_reg       <= 1'b0;
                scan_idx_reg <= '0;
            end
            else
            begin
                if (cmd.set_ok)
                begin
                    ok_reg <= 1'b1;
                end
                if (scan_issue)
                begin
                    scan_idx_reg <= scan_idx_reg + CW'(1);
                end
            end

            if (cmd.clear)
            begin
                pend_total_reg <= '0;
                ring_total_reg <= '0;
                ring_head_reg  <= '0;
            end
            else
            begin
                if (cmd.tab_append)
                begin
                    pend_total_reg <= pend_total_reg + CW'(1);
                end
                else if (cmd.tab_move)
                begin
                    pend_total_reg <= last_cnt;
                end
                if (cmd.ring_push)
                begin
                    ring_total_reg <= ring_total_reg + CW'(1);
                end
                else if (cmd.ring_pop)
                begin
                    ring_total_reg <= ring_total_reg - CW'(1);
                    ring_head_reg  <= head_inc;
                end
            end
        end
    end

    // counts are reported modulo sixteen
    assign pend_ext = {4'b0000, pend_total_reg};
    assign ring_ext = {4'b0000, ring_total_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            rsp_reg.ok            <= ok_reg;
            rsp_reg.feedback_id   <= fid_reg;
            rsp_reg.feedback_kind <= kind_reg;
            rsp_reg.pend_count    <= pend_ext[3:0];
            rsp_reg.queued_count  <= ring_ext[3:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign sts.op         = op_reg;
    assign sts.id_zero    = (id_reg == 32'd0);
    assign sts.tab_full   = (pend_total_reg == CW'(TABLE_DEPTH));
    assign sts.ring_full  = (ring_total_reg == CW'(TABLE_DEPTH));
    assign sts.ring_empty = (ring_total_reg == '0);
    assign sts.hit        = rd_vld_reg && (pend_rdata_reg == id_reg);
    assign sts.scan_end   = !rd_vld_reg && (scan_idx_reg == pend_total_reg);
    assign sts.out_free   = !rsp_valid_reg || !rsp_stall;

endmodule

// ----- design/correlation_feedback_tracker_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// correlation_feedback_tracker_unit
// Pending correlation id table with a ring of feedback entries.
// ----------------------------------------------------------------------------
// One transaction is handled at a time and answered with exactly one result.
// Service, disconnect, unused codes, pop of an empty ring and a track refused
// for id zero or a full table go from dispatch straight to the done state; a
// pop that returns an entry passes through the ring read and pop states. Track
// and command result search the pending table one entry per cycle through its
// single read port until a hit or the end of the table, and a matched command
// result that queues feedback then compacts the table through the last-entry
// read and move states. A finished result waits in the output register while
// the next transaction is accepted. No clearing pass is needed after reset.
module correlation_feedback_tracker_unit
    import cft_pkg::*;
#(
    parameter int TABLE_DEPTH = CFT_TABLE_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_stall,
    input  item_t   req,
    output logic    rsp_valid,
    input  logic    rsp_stall,
    output result_t rsp
);

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    cft_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    cft_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cmd       (cmd),
        .sts       (sts)
    );

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ring_push |-> !sts.ring_full)
        else $error("feedback push into a full ring");

    a_append_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tab_append |-> !sts.tab_full)
        else $error("pending append into a full table");

    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("result written over an untaken result");

    a_emit_then_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> rsp_valid)
        else $error("emitted result not presented");

    a_one_table_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.tab_append, cmd.tab_move, cmd.clear}))
        else $error("conflicting pending table updates");

endmodule

// ----- tb/correlation_feedback_tracker_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// correlation_feedback_tracker_unit_tb
// Drives track, result, service, pop and disconnect transactions through the
// tracker under random idling and back-pressure, predicts every result with
// a local table and ring, and compares each returned result field by field.
// ----------------------------------------------------------------------------
module correlation_feedback_tracker_unit_tb;
    import cft_pkg::*;

    localparam int          TD            = CFT_TABLE_DEPTH;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          WATCHDOG_MAX  = 2000;
    localparam int          RANDOM_BATCH  = 490;
    localparam int          POOL_SIZE     = 12;
    localparam logic [2:0]  CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0]  CMD_UNUSED_HI = 3'd7;

    logic    clk       = 1'b0;
    logic    rst_n     = 1'b0;
    logic    req_valid = 1'b0;
    logic    req_stall;
    item_t   req       = '0;
    logic    rsp_valid;
    logic    rsp_stall = 1'b0;
    result_t rsp;

    // stimulus control, set at the falling edge; the driver takes items at the rising edge
    item_t       item_q[$];
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    logic        tx_hold     = 1'b0;
    int          hold_ticket = 0;

    // receiver hold-off bookkeeping, owned by the monitor
    int          hold_seen   = 0;
    int          hold_left   = 0;

    // expected results and predictor state
    result_t     result_q[$];
    logic [31:0] tab_ids [TD];
    int          tab_cnt = 0;
    ring_entry_t fb_ring [TD];
    int          fb_head = 0;
    int          fb_cnt  = 0;

    logic [31:0] id_pool [POOL_SIZE];
    int          fail_count = 0;
    int          quiet_cycles = 0;

    correlation_feedback_tracker_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic int tab_lookup(logic [31:0] id);
        for (int i = 0; i < tab_cnt; i++)
        begin
            if (tab_ids[i] == id)
                return i;
        end
        return -1;
    endfunction

    function automatic logic fb_push(logic [31:0] id, logic [1:0] kind);
        if (fb_cnt >= TD || id == '0)
            return 1'b0;
        fb_ring[(fb_head + fb_cnt) % TD] = '{kind: kind, id: id};
        fb_cnt++;
        return 1'b1;
    endfunction

    function automatic result_t predict_result(item_t it);
        result_t r;
        int      pos;
        r = '0;
        case (it.cmd)
            OP_TRACK:
            begin
                if (it.corr_id != '0 && tab_cnt < TD)
                begin
                    if (tab_lookup(it.corr_id) < 0)
                    begin
                        tab_ids[tab_cnt] = it.corr_id;
                        tab_cnt++;
                    end
                    r.ok = 1'b1;
                end
            end
            OP_RESULT:
            begin
                pos = tab_lookup(it.corr_id);
                // id stays pending when the ring cannot take the feedback
                if (pos >= 0 && fb_push(it.corr_id,
                                        it.accepted ? KIND_SEM_ACC : KIND_SEM_REJ))
                begin
                    for (int i = pos; i + 1 < tab_cnt; i++)
                        tab_ids[i] = tab_ids[i + 1];
                    tab_cnt--;
                    r.ok = 1'b1;
                end
            end
            OP_SERVICE:
                r.ok = fb_push(it.corr_id,
                               it.accepted ? KIND_SVC_ACC : KIND_SVC_REJ);
            OP_POP:
            begin
                if (fb_cnt > 0)
                begin
                    r.feedback_id   = fb_ring[fb_head].id;
                    r.feedback_kind = fb_ring[fb_head].kind;
                    fb_head = (fb_head + 1) % TD;
                    fb_cnt--;
                    r.ok = 1'b1;
                end
            end
            OP_DISC:
            begin
                tab_cnt = 0;
                fb_head = 0;
                fb_cnt  = 0;
            end
            default: ;
        endcase
        r.pend_count   = tab_cnt[3:0];
        r.queued_count = fb_cnt[3:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                result_q.push_back(predict_result(req));
            if (!req_valid || !req_stall)
            begin
                if (tx_hold || item_q.size() == 0 || $urandom_range(0, 99) < tx_idle_pct)
                    req_valid <= 1'b0;
                else
                begin
                    req       <= item_q.pop_front();
                    req_valid <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor and receiver stall
    // ------------------------------------------------------------------
    task automatic check_result(result_t got);
        result_t want;
        if (result_q.size() == 0)
        begin
            $error("unexpected result transaction: %p", got);
            fail_count++;
        end
        else
        begin
            want = result_q.pop_front();
            if (got.ok !== want.ok)
            begin
                $error("ok: expected %0d, got %0d", want.ok, got.ok);
                fail_count++;
            end
            if (got.feedback_id !== want.feedback_id)
            begin
                $error("feedback_id: expected %h, got %h", want.feedback_id, got.feedback_id);
                fail_count++;
            end
            if (got.feedback_kind !== want.feedback_kind)
            begin
                $error("feedback_kind: expected %0d, got %0d",
                       want.feedback_kind, got.feedback_kind);
                fail_count++;
            end
            if (got.pend_count !== want.pend_count)
            begin
                $error("pend_count: expected %0d, got %0d",
                       want.pend_count, got.pend_count);
                fail_count++;
            end
            if (got.queued_count !== want.queued_count)
            begin
                $error("queued_count: expected %0d, got %0d",
                       want.queued_count, got.queued_count);
                fail_count++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
                check_result(rsp);
            if (hold_seen != hold_ticket)
            begin
                hold_seen <= hold_ticket;
                hold_left <= HOLD_CYCLES;
                rsp_stall <= 1'b1;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // watchdog: cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_MAX)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    function automatic item_t mk_item(logic [2:0] c, logic [31:0] id, logic acc);
        item_t it;
        it.cmd      = c;
        it.corr_id  = id;
        it.accepted = acc;
        return it;
    endfunction

    function automatic logic [31:0] pick_id();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return id_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (r < 78)
            return '0;
        else
            return $urandom;
    endfunction

    function automatic item_t random_item();
        int unsigned r;
        logic        acc;
        r   = $urandom_range(0, 99);
        acc = 1'($urandom_range(0, 1));
        if (r < 30)
            return mk_item(OP_TRACK, pick_id(), acc);
        else if (r < 55)
            return mk_item(OP_RESULT, pick_id(), acc);
        else if (r < 68)
            return mk_item(OP_SERVICE, pick_id(), acc);
        else if (r < 93)
            return mk_item(OP_POP, $urandom, acc);
        else if (r < 95)
            return mk_item(OP_DISC, $urandom, acc);
        else if (r < 97)
            return mk_item(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), $urandom, acc);
        else
            return mk_item(OP_TRACK, $urandom, acc);
    endfunction

    task automatic push_random(int n);
        for (int i = 0; i < n; i++)
            item_q.push_back(random_item());
    endtask

    // wait until every queued transaction is sent and every result is back
    task automatic drain();
        while (item_q.size() != 0 || req_valid || result_q.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        id_pool[0] = 32'h0000_0001;
        id_pool[1] = 32'hFFFF_FFFF;
        id_pool[2] = 32'h8000_0000;
        for (int i = 3; i < POOL_SIZE; i++)
            id_pool[i] = $urandom | 32'h1;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // phase 1: light sender idling, heavy receiver stalling
        tx_idle_pct = 11;
        rx_idle_pct = 57;

        item_q.push_back(mk_item(OP_POP, 32'h0, 1'b0));         // empty ring
        item_q.push_back(mk_item(OP_TRACK, 32'h0, 1'b1));       // id zero
        item_q.push_back(mk_item(OP_RESULT, 32'h5, 1'b1));      // not pending
        item_q.push_back(mk_item(OP_SERVICE, 32'h0, 1'b1));     // id zero
        item_q.push_back(mk_item(OP_TRACK, 32'hFFFF_FFFF, 1'b0));
        item_q.push_back(mk_item(OP_TRACK, 32'hFFFF_FFFF, 1'b0)); // already present
        for (int i = 2; i <= TD; i++)
            item_q.push_back(mk_item(OP_TRACK, i, 1'b0));
        item_q.push_back(mk_item(OP_TRACK, 32'h2, 1'b0));       // full table, present id
        item_q.push_back(mk_item(OP_RESULT, 32'hFFFF_FFFF, 1'b1));
        item_q.push_back(mk_item(OP_RESULT, 32'h2, 1'b0));
        item_q.push_back(mk_item(OP_SERVICE, 32'h8000_0001, 1'b1));
        item_q.push_back(mk_item(OP_SERVICE, 32'h3, 1'b0));
        for (int i = 0; i < 4; i++)
            item_q.push_back(mk_item(OP_SERVICE, 32'h7FFF_FFFE - i, i[0]));
        item_q.push_back(mk_item(OP_SERVICE, 32'h9, 1'b1));     // ring full
        item_q.push_back(mk_item(OP_RESULT, 32'h3, 1'b1));      // ring full, stays pending
        item_q.push_back(mk_item(OP_POP, 32'h0, 1'b1));
        item_q.push_back(mk_item(CMD_UNUSED_HI, 32'hFFFF_FFFF, 1'b1));
        item_q.push_back(mk_item(OP_DISC, 32'hFFFF_FFFF, 1'b1));
        drain();

        push_random(RANDOM_BATCH);
        repeat (100) @(negedge clk);
        // long receiver hold-off while the sender keeps offering
        hold_ticket++;
        drain();

        // phase 2: heavy sender idling, light receiver stalling
        tx_idle_pct = 57;
        rx_idle_pct = 11;
        push_random(RANDOM_BATCH);
        drain();

        // phase 3: no idling, with one sender pause until all results are back
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        push_random(RANDOM_BATCH);
        repeat (200) @(negedge clk);
        tx_hold = 1'b1;
        while (req_valid || result_q.size() != 0)
            @(negedge clk);
        tx_hold = 1'b0;
        drain();

        repeat (40) @(negedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/cft_pkg.sv
design/cft_ctrl.sv
design/cft_datapath.sv
design/correlation_feedback_tracker_unit.sv
tb/correlation_feedback_tracker_unit_tb.sv
